FILE: rtl/mf3_pkg.sv
package mf3_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  // column index, row index, and the register widths that can hold the maxima
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W  = COL_W + 1;
  localparam int HEIGHT_W = ROW_W + 1;
  localparam int CFG_W    = HEIGHT_W;

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN   = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
  localparam logic [WIDTH_W-1:0]  WIDTH_RST   = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN  = HEIGHT_W'(3);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = HEIGHT_W'(MAX_HEIGHT);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST  = HEIGHT_W'(480);

  // configuration register indexes
  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  typedef logic [7:0] pix_t;

  typedef struct packed {
    pix_t pixel;
    logic frame_start;
  } mf3_in_t;

  typedef struct packed {
    pix_t             result_pixel;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             run_last;
    logic             frame_done;
  } mf3_out_t;

endpackage

FILE: rtl/mf3_median9.sv
module mf3_median9 import mf3_pkg::*; (
  input  pix_t win [9],
  output pix_t med
);

  pix_t p [9];

  function automatic logic [15:0] sort2(input pix_t a, input pix_t b);
    return (a > b) ? {b, a} : {a, b};
  endfunction

  // 19 compare-exchange median network; only p[4] is fully ordered
  always_comb begin
    p = win;
    {p[1], p[2]} = sort2(p[1], p[2]);
    {p[4], p[5]} = sort2(p[4], p[5]);
    {p[7], p[8]} = sort2(p[7], p[8]);
    {p[0], p[1]} = sort2(p[0], p[1]);
    {p[3], p[4]} = sort2(p[3], p[4]);
    {p[6], p[7]} = sort2(p[6], p[7]);
    {p[1], p[2]} = sort2(p[1], p[2]);
    {p[4], p[5]} = sort2(p[4], p[5]);
    {p[7], p[8]} = sort2(p[7], p[8]);
    {p[0], p[3]} = sort2(p[0], p[3]);
    {p[5], p[8]} = sort2(p[5], p[8]);
    {p[4], p[7]} = sort2(p[4], p[7]);
    {p[3], p[6]} = sort2(p[3], p[6]);
    {p[1], p[4]} = sort2(p[1], p[4]);
    {p[2], p[5]} = sort2(p[2], p[5]);
    {p[4], p[7]} = sort2(p[4], p[7]);
    {p[4], p[2]} = sort2(p[4], p[2]);
    {p[6], p[4]} = sort2(p[6], p[4]);
    {p[4], p[2]} = sort2(p[4], p[2]);
  end

  assign med = p[4];

endmodule

FILE: rtl/median_filter_3x3_top.sv
// A result is registered in stage 1 and then in the stage 2 result register.
// One input beat per cycle while the result side keeps up; one result per cycle while
// out_ready is high. A beat with several results holds the next result-producing beat
// until all are sent (two at a row end or in the last row, four at frame end).
// The line store is a 2048 x 16 single-port-write memory read once per accepted beat.
// Reset (synchronous, rst_n low) clears position, window and pipeline, loads 640 x 480.
module median_filter_3x3_top import mf3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mf3_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mf3_out_t           out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int SLOT_MED  = 0;
  localparam int SLOT_EDGE = 1;
  localparam int SLOT_LROW = 2;
  localparam int SLOT_LAST = 3;

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;

  // stage 1
  logic             s1_valid_r;
  pix_t             s1_pix_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic [3:0]       s1_mask_r;
  logic             s1_med_r;
  logic             s1_byp_r;
  logic [15:0]      s1_byp_data_r;
  logic [15:0]      mem_rd_r;
  logic [15:0]      line_mem [MAX_WIDTH];

  // window columns 1 and 2 of rows 0..2 after the last shift
  pix_t wa_r [3];
  pix_t wb_r [3];

  // stage 2
  logic [3:0]       s2_mask_r;
  pix_t             s2_val_r [4];
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;

  logic                in_fire, s1_fire, s2_free, out_fire, out_last;
  logic [3:0]          s2_rem;
  logic [COL_W-1:0]    c_s, c_a;
  logic [ROW_W-1:0]    r_s, r_a;
  logic [HEIGHT_W-1:0] r_t, r1;
  logic [WIDTH_W-1:0]  c1;
  logic                last_c, last_r, r_ge1, c_ge1;
  logic [3:0]          mask_nxt;
  logic                med_nxt;
  logic [15:0]         line_rd;
  pix_t                older, newer, med;
  pix_t                win [9];
  logic [WIDTH_W-1:0]  cfg_w;
  logic [HEIGHT_W-1:0] cfg_h;
  logic [1:0]          slot;

  // ---------------- position of the incoming beat ----------------
  always_comb begin
    c_s = in_data.frame_start ? '0 : col_r;
    r_s = in_data.frame_start ? '0 : row_r;
    c_a = c_s;
    r_t = {1'b0, r_s};
    if ({1'b0, c_s} >= width_r) begin
      c_a = '0;
      r_t = {1'b0, r_s} + HEIGHT_W'(1);
    end
    r_a    = (r_t >= height_r) ? '0 : r_t[ROW_W-1:0];
    c1     = {1'b0, c_a} + WIDTH_W'(1);
    r1     = {1'b0, r_a} + HEIGHT_W'(1);
    last_c = (c1 == width_r);
    last_r = (r1 == height_r);
    r_ge1  = (r_a != '0);
    c_ge1  = (c_a != '0);
    mask_nxt[SLOT_MED]  = r_ge1 && c_ge1;
    mask_nxt[SLOT_EDGE] = r_ge1 && last_c;
    mask_nxt[SLOT_LROW] = last_r && c_ge1;
    mask_nxt[SLOT_LAST] = last_r && last_c;
    med_nxt = (r_a > ROW_W'(1)) && (c_a > COL_W'(1));
    if (last_c) begin
      col_nxt = '0;
      row_nxt = last_r ? '0 : r1[ROW_W-1:0];
    end else begin
      col_nxt = c1[COL_W-1:0];
      row_nxt = r_a;
    end
  end

  // ---------------- handshake ----------------
  assign s2_rem   = s2_mask_r & (s2_mask_r - 4'd1);
  assign out_last = (s2_rem == '0);
  assign out_fire = out_valid && out_ready;
  assign s2_free  = !out_valid || (out_ready && out_last);
  assign s1_fire  = s1_valid_r && ((s1_mask_r == '0) || s2_free);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // ---------------- configuration ----------------
  always_comb begin
    cfg_w = cfg_wdata[WIDTH_W-1:0];
    if (cfg_w < WIDTH_MIN) cfg_w = WIDTH_MIN;
    if (cfg_w > WIDTH_MAX) cfg_w = WIDTH_MAX;
    cfg_h = cfg_wdata[HEIGHT_W-1:0];
    if (cfg_h < HEIGHT_MIN) cfg_h = HEIGHT_MIN;
    if (cfg_h > HEIGHT_MAX) cfg_h = HEIGHT_MAX;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_w;
        CFG_IMAGE_HEIGHT: height_r <= cfg_h;
        default: ;
      endcase
    end
  end

  // ---------------- line store ----------------
  // entry holds {row r-2, row r-1} of one column
  assign line_rd = s1_byp_r ? s1_byp_data_r : mem_rd_r;
  assign older   = line_rd[15:8];
  assign newer   = line_rd[7:0];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mem_rd_r <= line_mem[c_a];
    end
    if (s1_fire) begin
      line_mem[s1_col_r] <= {newer, s1_pix_r};
    end
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      row_r      <= '0;
      col_r      <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        row_r      <= row_nxt;
        col_r      <= col_nxt;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r      <= in_data.pixel;
      s1_row_r      <= r_a;
      s1_col_r      <= c_a;
      s1_mask_r     <= mask_nxt;
      s1_med_r      <= med_nxt;
      // forward the write that lands on this same column at this edge
      s1_byp_r      <= s1_fire && (s1_col_r == c_a);
      s1_byp_data_r <= {newer, s1_pix_r};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win[3*i]     = wa_r[i];
      win[3*i + 1] = wb_r[i];
    end
    win[2] = older;
    win[5] = newer;
    win[8] = s1_pix_r;
  end

  mf3_median9 u_median (
    .win (win),
    .med (med)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        wa_r[i] <= '0;
        wb_r[i] <= '0;
      end
    end else if (s1_fire) begin
      for (int i = 0; i < 3; i++) begin
        wa_r[i] <= wb_r[i];
      end
      wb_r[0] <= older;
      wb_r[1] <= newer;
      wb_r[2] <= s1_pix_r;
    end
  end

  // ---------------- stage 2: result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_mask_r <= '0;
    end else if (s1_fire && (s1_mask_r != '0)) begin
      s2_mask_r <= s1_mask_r;
    end else if (out_fire) begin
      s2_mask_r <= s2_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_mask_r != '0)) begin
      s2_val_r[SLOT_MED]  <= s1_med_r ? med : wb_r[1];
      s2_val_r[SLOT_EDGE] <= newer;
      s2_val_r[SLOT_LROW] <= wb_r[2];
      s2_val_r[SLOT_LAST] <= s1_pix_r;
      s2_row_r            <= s1_row_r;
      s2_col_r            <= s1_col_r;
    end
  end

  // send the lowest pending slot first
  always_comb begin
    if (s2_mask_r[SLOT_MED])       slot = 2'(SLOT_MED);
    else if (s2_mask_r[SLOT_EDGE]) slot = 2'(SLOT_EDGE);
    else if (s2_mask_r[SLOT_LROW]) slot = 2'(SLOT_LROW);
    else                           slot = 2'(SLOT_LAST);
  end

  assign out_valid = (s2_mask_r != '0);

  always_comb begin
    out_data.result_pixel = s2_val_r[slot];
    out_data.out_row      = (slot[1] == 1'b0) ? s2_row_r - ROW_W'(1) : s2_row_r;
    out_data.out_col      = (slot[0] == 1'b0) ? s2_col_r - COL_W'(1) : s2_col_r;
    out_data.run_last     = out_last;
    out_data.frame_done   = (slot == 2'(SLOT_LAST));
  end

endmodule

FILE: rtl/mf3_checker.sv
module mf3_checker import mf3_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input mf3_out_t           out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // results of one input beat go out back to back
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.run_last |=> out_valid)
    else $error("gap inside a run of results");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> out_data.run_last)
    else $error("frame_done on a beat that is not the last of its run");

  a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_done |-> (out_data.out_row != '0) && (out_data.out_col != '0))
    else $error("frame_done at an impossible position");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind median_filter_3x3_top mf3_checker u_mf3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/median_filter_3x3_top_tb.sv
`timescale 1ns / 1ps
module median_filter_3x3_top_tb;
  import mf3_pkg::*;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_e;

  // one step of the directed sequence: a beat (value = pixel) or a size write
  typedef struct packed {
    row_kind_e        kind;
    logic             reg_idx;
    logic             sof;
    logic [CFG_W-1:0] value;
    logic             chk;
    logic [2:0]       n_res;
    pix_t             last_pix;
  } dir_row_t;

  localparam int DIR_ROWS     = 31;
  localparam int QUIET_CYCLES = 8;
  localparam int RND_BEATS    = 80;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  mf3_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  mf3_out_t         out_data;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  // typed-in outcome of the beat on offer, compared with the filter model
  logic             chk_on;
  logic [2:0]       chk_n;
  pix_t             chk_pix;

  // filter model: line stores, window, position and size
  pix_t ls_far  [MAX_WIDTH];
  pix_t ls_near [MAX_WIDTH];
  pix_t win [3][3];
  int   row_q    = 0;
  int   col_q    = 0;
  int   width_q  = int'(WIDTH_RST);
  int   height_q = int'(HEIGHT_RST);

  mf3_out_t px_due [$];
  int       errors      = 0;
  int       beats_in    = 0;
  int       results_out = 0;
  bit       hold_req    = 1'b0;

  median_filter_3x3_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[median_filter_3x3_top] ERROR");
    $finish;
  end

  function automatic pix_t median_of_window();
    pix_t v [9];
    int   lt;
    int   le;
    pix_t m;
    m = '0;
    for (int i = 0; i < 9; i++) v[i] = win[i / 3][i % 3];
    // the median has at most four values below it and at least five at or below
    for (int i = 0; i < 9; i++) begin
      lt = 0;
      le = 0;
      for (int j = 0; j < 9; j++) begin
        if (v[j] < v[i]) lt++;
        if (v[j] <= v[i]) le++;
      end
      if (lt <= 4 && le >= 5) m = v[i];
    end
    return m;
  endfunction

  function automatic mf3_out_t px_at(input pix_t v, input int r, input int c,
                                     input logic done);
    mf3_out_t o;
    o.result_pixel = v;
    o.out_row      = ROW_W'(r);
    o.out_col      = COL_W'(c);
    o.run_last     = 1'b0;
    o.frame_done   = done;
    return o;
  endfunction

  function automatic pix_t any_px();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic take_size_write(input logic idx, input logic [CFG_W-1:0] data);
    int v;
    if (idx == CFG_IMAGE_WIDTH) begin
      v = int'(data[WIDTH_W-1:0]);
      width_q = (v < WIDTH_MIN) ? WIDTH_MIN : (v > WIDTH_MAX) ? WIDTH_MAX : v;
    end else begin
      v = int'(data[HEIGHT_W-1:0]);
      height_q = (v < HEIGHT_MIN) ? HEIGHT_MIN : (v > HEIGHT_MAX) ? HEIGHT_MAX : v;
    end
  endtask

  task automatic predict_beat(input mf3_in_t b);
    mf3_out_t outs [4];
    int       n;
    int       r;
    int       c;
    pix_t     up2;
    pix_t     up1;
    n = 0;
    if (b.frame_start) begin
      row_q = 0;
      col_q = 0;
    end
    // wrap a position left stale by a smaller size
    if (col_q >= width_q) begin
      col_q = 0;
      row_q++;
    end
    if (row_q >= height_q) row_q = 0;
    r = row_q;
    c = col_q;

    up2 = ls_far[c];
    up1 = ls_near[c];
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = b.pixel;
    ls_far[c]  = up1;
    ls_near[c] = b.pixel;

    if (r >= 1 && c >= 1) begin
      outs[n] = px_at((r >= 2 && c >= 2) ? median_of_window() : win[1][1], r - 1, c - 1, 1'b0);
      n = n + 1;
    end
    if (r >= 1 && c == width_q - 1) begin
      outs[n] = px_at(win[1][2], r - 1, c, 1'b0);
      n = n + 1;
    end
    if (r == height_q - 1 && c >= 1) begin
      outs[n] = px_at(win[2][1], r, c - 1, 1'b0);
      n = n + 1;
    end
    if (r == height_q - 1 && c == width_q - 1) begin
      outs[n] = px_at(win[2][2], r, c, 1'b1);
      n = n + 1;
    end
    if (n > 0) outs[n - 1].run_last = 1'b1;

    if (chk_on) begin
      if (n != int'(chk_n)) begin
        $error("results per beat exp %0d got %0d", chk_n, n);
        errors++;
      end else if (n > 0 && outs[n - 1].result_pixel != chk_pix) begin
        $error("result_pixel exp %0d got %0d", chk_pix, outs[n - 1].result_pixel);
        errors++;
      end
    end
    for (int i = 0; i < n; i++) px_due.push_back(outs[i]);

    col_q = c + 1;
    if (col_q >= width_q) begin
      col_q = 0;
      row_q = r + 1;
      if (row_q >= height_q) row_q = 0;
    end
  endtask

  always @(posedge clk) begin : monitor_p
    mf3_out_t want;
    if (rst_n) begin
      if (cfg_we) take_size_write(cfg_index, cfg_wdata);
      if (in_valid && in_ready) begin
        beats_in++;
        predict_beat(in_data);
      end
      if (out_valid && out_ready) begin
        results_out++;
        if (px_due.size() == 0) begin
          $error("unexpected result: row %0d col %0d pixel %0d",
                 out_data.out_row, out_data.out_col, out_data.result_pixel);
          errors++;
        end else begin
          want = px_due.pop_front();
          if (out_data.result_pixel !== want.result_pixel) begin
            $error("result_pixel exp %0d got %0d", want.result_pixel, out_data.result_pixel);
            errors++;
          end
          if (out_data.out_row !== want.out_row) begin
            $error("out_row exp %0d got %0d", want.out_row, out_data.out_row);
            errors++;
          end
          if (out_data.out_col !== want.out_col) begin
            $error("out_col exp %0d got %0d", want.out_col, out_data.out_col);
            errors++;
          end
          if (out_data.run_last !== want.run_last) begin
            $error("run_last exp %0d got %0d", want.run_last, out_data.run_last);
            errors++;
          end
          if (out_data.frame_done !== want.frame_done) begin
            $error("frame_done exp %0d got %0d", want.frame_done, out_data.frame_done);
            errors++;
          end
        end
      end
    end
  end

  // result side: random stalls, a calm stretch, and one long hold-off to back the filter up
  initial begin : sink_p
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && hold_req) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      out_ready <= (results_out >= 25 && results_out < 55) || ($urandom_range(0, 99) >= 34);
    end
  end

  task automatic send_beat(input pix_t px, input logic sof, input logic chk,
                           input logic [2:0] n_res, input pix_t last_pix);
    @(negedge clk);
    while (!(beats_in >= 40 && beats_in < 90) && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{pixel: px, frame_start: sof};
    chk_on   <= chk;
    chk_n    <= n_res;
    chk_pix  <= last_pix;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, wait out every pending result, then let beats with no result settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    chk_on   <= 1'b0;
    while (px_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic idx, input logic [CFG_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stim_p
    dir_row_t         dir_tab [DIR_ROWS];
    int               w;
    int               h;
    int               npx;
    int               rnd_beats;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    chk_on    = 1'b0;
    chk_n     = '0;
    chk_pix   = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;

    dir_tab = '{
      // reset size is 640 x 480: row 0 gives nothing
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b1, 13'd10,   1'b1, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd20,   1'b1, 3'd0, 8'd0},
      // bit 12 is masked off, then 0 saturates to 3; height 0 saturates to 3
      '{ROW_CFG,  CFG_IMAGE_WIDTH,  1'b0, 13'h1000, 1'b0, 3'd0, 8'd0},
      '{ROW_CFG,  CFG_IMAGE_HEIGHT, 1'b0, 13'd0,    1'b0, 3'd0, 8'd0},
      // smallest frame: one median, all borders, four results on the last beat
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b1, 13'd0,    1'b1, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd255,  1'b1, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd128,  1'b1, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd255,  1'b1, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd0,    1'b1, 3'd1, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd1,    1'b1, 3'd2, 8'd128},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd254,  1'b1, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd7,    1'b1, 3'd2, 8'd254},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd255,  1'b1, 3'd4, 8'd255},
      // 4 x 5 frame, stopped inside row 2
      '{ROW_CFG,  CFG_IMAGE_WIDTH,  1'b0, 13'd4,    1'b0, 3'd0, 8'd0},
      '{ROW_CFG,  CFG_IMAGE_HEIGHT, 1'b0, 13'd5,    1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b1, 13'd255,  1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd0,    1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd17,   1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd200,  1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd3,    1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd255,  1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd0,    1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd128,  1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd64,   1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd250,  1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd1,    1'b0, 3'd0, 8'd0},
      // shrink mid-frame: column 3 wraps to row 3, which wraps to row 0
      '{ROW_CFG,  CFG_IMAGE_WIDTH,  1'b0, 13'd3,    1'b0, 3'd0, 8'd0},
      '{ROW_CFG,  CFG_IMAGE_HEIGHT, 1'b0, 13'd3,    1'b0, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd90,   1'b1, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd0,    1'b1, 3'd0, 8'd0},
      '{ROW_BEAT, CFG_IMAGE_WIDTH,  1'b0, 13'd255,  1'b1, 3'd0, 8'd0}
    };

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG)
        write_size(dir_tab[i].reg_idx, dir_tab[i].value);
      else
        send_beat(dir_tab[i].value[7:0], dir_tab[i].sof, dir_tab[i].chk,
                  dir_tab[i].n_res, dir_tab[i].last_pix);
    end

    // random sizes; whole frames mostly, some cut short or restarted mid-frame
    rnd_beats = 0;
    while (rnd_beats < RND_BEATS) begin
      w  = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(3, 8);
      h  = $urandom_range(3, 6);
      wv = CFG_W'(w);
      hv = CFG_W'(h);
      case ($urandom_range(0, 5))
        0: begin
          w  = 3;
          wv = CFG_W'($urandom_range(0, 2));
        end
        1: wv = (CFG_W'(1) << WIDTH_W) | CFG_W'(w);
        2: begin
          h  = 3;
          hv = CFG_W'($urandom_range(0, 2));
        end
        default: ;
      endcase
      write_size(CFG_IMAGE_WIDTH, wv);
      write_size(CFG_IMAGE_HEIGHT, hv);
      // the first beat after a size write always starts a frame
      for (int f = 0; f < $urandom_range(1, 2); f++) begin
        npx = w * h;
        if ($urandom_range(0, 5) == 0) npx = $urandom_range(1, npx - 1);
        for (int p = 0; p < npx && rnd_beats < RND_BEATS; p++) begin
          send_beat(any_px(),
                    (p == 0 && (f == 0 || $urandom_range(0, 3) != 0)) ||
                    $urandom_range(0, 99) < 2,
                    1'b0, 3'd0, 8'd0);
          rnd_beats++;
        end
      end
    end

    // wide row: the 12-bit mask leaves 2051, saturated to 2048; row 0 gives nothing
    write_size(CFG_IMAGE_WIDTH, CFG_W'(12'h803));
    write_size(CFG_IMAGE_HEIGHT, CFG_W'(3));
    for (int p = 0; p < 20; p++) send_beat(any_px(), p == 0, 1'b0, 3'd0, 8'd0);

    // tall frame: 8191 saturates to 4096; the result side holds off meanwhile
    write_size(CFG_IMAGE_WIDTH, CFG_W'(3));
    write_size(CFG_IMAGE_HEIGHT, '1);
    hold_req = 1'b1;
    for (int p = 0; p < 15; p++) send_beat(any_px(), p == 0, 1'b0, 3'd0, 8'd0);

    drain();
    if (errors == 0)
      $display("[median_filter_3x3_top] OK");
    else
      $display("[median_filter_3x3_top] ERROR");
    $finish;
  end

endmodule
